// ===== src/psda_pkg.sv =====
// Package for the point store distance/angle block: widths, kind codes,
// status codes and the CORDIC arctangent table. No dependencies.
package psda_pkg;

   localparam int POINTS      = 8;
   localparam int IDX_W       = $clog2(POINTS);
   localparam int STEPS       = 29;
   localparam int CW          = 44;   // CORDIC datapath width
   localparam int ACC_W       = 34;
   localparam int SQ_W        = 52;   // (dx^2+dy^2)<<16 needs 49 bits; even width for the root
   localparam int ROOT_W      = 26;
   localparam int MAX_ANGLE   = 46080;
   localparam logic signed [ACC_W-1:0] NINETY_DEG = 34'sd1509949440;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_DIST   = 2'd1;
   localparam logic [1:0] KIND_ANGLE  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;

   // atan(2^-i) in degrees, Q24
   function automatic logic [ACC_W-1:0] atan_q24(input logic [4:0] i);
      logic [ACC_W-1:0] v;
      begin
         case (i)
            5'd0:  v = 34'd754974720;
            5'd1:  v = 34'd445687602;
            5'd2:  v = 34'd235489088;
            5'd3:  v = 34'd119537938;
            5'd4:  v = 34'd60000934;
            5'd5:  v = 34'd30029717;
            5'd6:  v = 34'd15018523;
            5'd7:  v = 34'd7509720;
            5'd8:  v = 34'd3754917;
            5'd9:  v = 34'd1877466;
            5'd10: v = 34'd938734;
            5'd11: v = 34'd469367;
            5'd12: v = 34'd234684;
            5'd13: v = 34'd117342;
            5'd14: v = 34'd58671;
            5'd15: v = 34'd29335;
            5'd16: v = 34'd14668;
            5'd17: v = 34'd7334;
            5'd18: v = 34'd3667;
            5'd19: v = 34'd1833;
            5'd20: v = 34'd917;
            5'd21: v = 34'd458;
            5'd22: v = 34'd229;
            5'd23: v = 34'd115;
            5'd24: v = 34'd57;
            5'd25: v = 34'd29;
            5'd26: v = 34'd14;
            5'd27: v = 34'd7;
            5'd28: v = 34'd4;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

// ===== src/psda_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module psda_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== src/point_store_distance_angle.sv =====
// Top level: point store, sequencer, one shared multiplier, a restoring
// square root and a CORDIC. Uses psda_pkg and psda_ram.
//
//  channel | dir | fields (tdata lsb first)
//  req     | in  | kind[1:0] first[5:2] second[9:6] third[13:10] x[29:14] y[45:30]
//  rsp     | out | status[1:0] distance[26:2] angle_degrees[42:27]
//  csr     | in  | point_count[3:0]
//
// After the accepting edge, a load, an unused kind or a bad index goes
// straight to the output state. Distance: 3 reads, 2 squares, 26 root steps,
// output. Angle: 3 reads, zero check, 4 products, normalize steps set by the
// operand size, CORDIC steps, output; a zero-length vector ends early.
// One item at a time; req_tready is low while busy and while a result waits
// in the output register, and returns the cycle after the rsp transfer.
module point_store_distance_angle
   import psda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // kind, first, second, third, x, y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status, distance, angle_degrees
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data  // point_count
);

   typedef enum logic [3:0] {
      S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_MUL, S_SQRT, S_NORM, S_CORDIC, S_OUT
   } state_type;

   state_type state_ff;
   logic [3:0] count_ff;
   logic [1:0] kind_ff;
   logic [3:0] ia_ff, ib_ff, ic_ff;
   logic [4:0] step_ff;
   logic [2:0] mstep_ff;
   logic signed [16:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic [31:0] pa_ff;
   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [SQ_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [SQ_W-1:0] n_ff;
   logic [1:0] st_ff;
   logic [24:0] dist_ff;
   logic [15:0] ang_ff;
   logic rv_ff;

   // point store
   logic        ram_we;
   logic [IDX_W-1:0] ram_ra;
   logic [31:0] ram_rd;
   psda_ram #(.WIDTH(32), .DEPTH(POINTS)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(req_tdata[2+IDX_W-1:2]),
      .wr_data(req_tdata[45:14]), .rd_addr(ram_ra), .rd_data(ram_rd));

   wire acc_in = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign ram_we = acc_in && (req_tdata[1:0] == KIND_LOAD) && (req_tdata[5:2] < POINTS);

   logic [3:0] limit;
   assign limit = (count_ff < POINTS) ? count_ff : 4'(POINTS);
   always_comb begin
      case (state_ff)
         S_RD_B:  ram_ra = ib_ff[IDX_W-1:0];
         S_RD_C:  ram_ra = ic_ff[IDX_W-1:0];
         default: ram_ra = ia_ff[IDX_W-1:0];
      endcase
   end

   // shared multiplier: 17x17 signed
   logic signed [16:0] m_a, m_b;
   logic signed [33:0] m_p;
   always_comb begin
      case (mstep_ff)
         3'd0: begin m_a = ax_ff; m_b = ax_ff; end
         3'd1: begin m_a = ay_ff; m_b = ay_ff; end
         3'd2: begin m_a = ax_ff; m_b = bx_ff; end
         3'd3: begin m_a = ay_ff; m_b = by_ff; end
         3'd4: begin m_a = ax_ff; m_b = by_ff; end
         default: begin m_a = ay_ff; m_b = bx_ff; end
      endcase
   end
   assign m_p = m_a * m_b;

   // CORDIC shifts
   logic signed [CW-1:0] xs, ys;
   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;

   // sqrt step: restoring, two bits per step
   logic [SQ_W+1:0] trial;
   logic [SQ_W+1:0] rem_sh;
   assign rem_sh = {rem_ff[SQ_W-1:0], n_ff[SQ_W-1 -: 2]};
   assign trial  = rem_sh - {{(SQ_W-ROOT_W){1'b0}}, root_ff, 2'b01};

   logic signed [ACC_W-1:0] acc_rnd;
   assign acc_rnd = (acc_ff + 34'sd32768) >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) count_ff <= csr_wr_data;
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (acc_in) begin
                  kind_ff <= req_tdata[1:0];
                  ia_ff <= req_tdata[5:2];
                  ib_ff <= req_tdata[9:6];
                  ic_ff <= req_tdata[13:10];
                  st_ff <= ST_OK; dist_ff <= '0; ang_ff <= '0;
                  case (req_tdata[1:0])
                     KIND_LOAD: begin
                        if (req_tdata[5:2] >= POINTS) st_ff <= ST_RANGE;
                        state_ff <= S_OUT;
                     end
                     KIND_DIST: begin
                        if (req_tdata[5:2] >= limit || req_tdata[9:6] >= limit) begin
                           st_ff <= ST_RANGE; state_ff <= S_OUT;
                        end else state_ff <= S_RD_A;
                     end
                     KIND_ANGLE: begin
                        if (req_tdata[5:2] >= limit || req_tdata[9:6] >= limit ||
                            req_tdata[13:10] >= limit) begin
                           st_ff <= ST_RANGE; state_ff <= S_OUT;
                        end else state_ff <= S_RD_A;
                     end
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_RD_A: state_ff <= S_RD_B;   // a address out
            S_RD_B: begin                 // a data arrives
               pa_ff <= ram_rd;
               state_ff <= S_RD_C;
            end
            S_RD_C: begin                 // b data arrives
               ax_ff <= 17'(signed'(ram_rd[15:0]))  - 17'(signed'(pa_ff[15:0]));
               ay_ff <= 17'(signed'(ram_rd[31:16])) - 17'(signed'(pa_ff[31:16]));
               state_ff <= S_MUL;
               mstep_ff <= (kind_ff == KIND_DIST) ? 3'd0 : 3'd2;
               x_ff <= '0; y_ff <= '0;
            end
            S_MUL: begin
               if (mstep_ff == 3'd2 && kind_ff == KIND_ANGLE && x_ff == '0) begin
                  // first angle cycle: latch to-vector (read of c), check zeros
                  bx_ff <= 17'(signed'(ram_rd[15:0]))  - 17'(signed'(pa_ff[15:0]));
                  by_ff <= 17'(signed'(ram_rd[31:16])) - 17'(signed'(pa_ff[31:16]));
                  x_ff  <= 44'sd1;   // marker: vector latched
                  if (ax_ff == 0 && ay_ff == 0) begin
                     st_ff <= ST_ZERO; state_ff <= S_OUT;
                  end
               end else begin
                  case (mstep_ff)
                     3'd0: begin n_ff <= SQ_W'(m_p); mstep_ff <= 3'd1; end
                     3'd1: begin
                        n_ff <= SQ_W'({n_ff[33:0] + 34'(m_p), 16'd0});
                        rem_ff <= '0; root_ff <= '0; step_ff <= '0;
                        state_ff <= S_SQRT;
                     end
                     3'd2: begin
                        if (bx_ff == 0 && by_ff == 0) begin
                           st_ff <= ST_ZERO; state_ff <= S_OUT;
                        end
                        x_ff <= CW'(m_p); mstep_ff <= 3'd3;
                     end
                     3'd3: begin x_ff <= x_ff + CW'(m_p); mstep_ff <= 3'd4; end
                     3'd4: begin y_ff <= CW'(m_p); mstep_ff <= 3'd5; end
                     default: begin
                        y_ff <= (y_ff - CW'(m_p) < 0) ? CW'(m_p) - y_ff : y_ff - CW'(m_p);
                        acc_ff <= '0;
                        state_ff <= S_NORM;
                     end
                  endcase
               end
            end
            S_SQRT: begin
               n_ff <= n_ff << 2;
               if (!trial[SQ_W+1]) begin
                  rem_ff <= trial; root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh; root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(ROOT_W - 1)) begin
                  state_ff <= S_OUT;
                  // round: remainder > root means round up
                  if (!trial[SQ_W+1])
                     dist_ff <= 25'({root_ff, 1'b1}) +
                                25'(trial > {{(SQ_W-ROOT_W+1){1'b0}}, root_ff, 1'b1});
                  else
                     dist_ff <= 25'({root_ff, 1'b0}) +
                                25'(rem_sh > {{(SQ_W-ROOT_W+1){1'b0}}, root_ff, 1'b0});
               end
            end
            S_NORM: begin
               if (x_ff < 0) begin
                  x_ff <= y_ff; y_ff <= -x_ff; acc_ff <= NINETY_DEG;
               end else if (x_ff < (44'sd1 <<< 38) && y_ff < (44'sd1 <<< 38)) begin
                  x_ff <= x_ff <<< 1; y_ff <= y_ff <<< 1;
               end else begin
                  step_ff <= '0; state_ff <= S_CORDIC;
               end
            end
            S_CORDIC: begin
               // last pass only rounds and clamps the accumulator
               if (step_ff == 5'(STEPS)) begin
                  state_ff <= S_OUT;
                  if (acc_ff < 0) ang_ff <= '0;
                  else if (acc_rnd > MAX_ANGLE) ang_ff <= 16'(MAX_ANGLE);
                  else ang_ff <= acc_rnd[15:0];
               end else begin
                  if (y_ff >= 0) begin
                     x_ff <= x_ff + ys; y_ff <= y_ff - xs;
                     acc_ff <= acc_ff + signed'(atan_q24(step_ff));
                  end else begin
                     x_ff <= x_ff - ys; y_ff <= y_ff + xs;
                     acc_ff <= acc_ff - signed'(atan_q24(step_ff));
                  end
                  step_ff <= step_ff + 5'd1;
               end
            end
            S_OUT: begin
               rv_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {5'd0, ang_ff, dist_ff, st_ff};

   // status for a distance query is never zero-length
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind_ff == KIND_DIST |-> st_ff != ST_ZERO)
      else $error("distance reported zero-length");
   // not ready while busy
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("ready while busy");
   // non-ok status carries zero values
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff != ST_OK |-> dist_ff == '0 && ang_ff == '0)
      else $error("bad status with nonzero value");

endmodule

// ===== tb/sv/psda_checker.sv =====
// Checker for the point store distance/angle block: watches the req and rsp
// channels and the csr write port, predicts each result and compares it.
// Depends on psda_pkg for kind and status codes.
`timescale 1ns / 100ps
module psda_checker
   import psda_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [15:0] angle_degrees;
      logic [24:0] distance;
      logic [1:0]  status;
   } answer_t;

   answer_t     answers_due[$];
   logic [31:0] model_points[POINTS];
   logic [3:0]  model_count;

   // arctangent table, degrees Q24
   longint atan_table[29] = '{
      754974720, 445687602, 235489088, 119537938, 60000934,
      30029717, 15018523, 7509720, 3754917, 1877466,
      938734, 469367, 234684, 117342, 58671,
      29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57,
      29, 14, 7, 4};

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [63:0] int_root(logic [63:0] n);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] cordic_angle(longint x, longint y);
      longint acc, t, xs, ys;
      acc = 0;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         acc = 1509949440;
      end
      if (x == 0 && y == 0) return 0;
      while (x < (64'sd1 <<< 38) && y < (64'sd1 <<< 38)) begin
         x = x * 2;
         y = y * 2;
      end
      for (int i = 0; i < 29; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; acc += atan_table[i];
         end else begin
            x -= ys; y += xs; acc -= atan_table[i];
         end
      end
      if (acc < 0) return 0;
      acc = (acc + 32768) >>> 16;
      if (acc > MAX_ANGLE) acc = MAX_ANGLE;
      return acc[15:0];
   endfunction

   function automatic longint pt_x(int k);
      return longint'($signed(model_points[k][15:0]));
   endfunction

   function automatic longint pt_y(int k);
      return longint'($signed(model_points[k][31:16]));
   endfunction

   function automatic answer_t predict_answer(logic [47:0] d);
      answer_t     r;
      logic [1:0]  kind;
      int          a, b, c, lim;
      longint      dx, dy, ax, ay, bx, by, dotp, crs;
      logic [63:0] n, root;
      r = '0;
      kind = d[1:0];
      a = d[5:2];
      b = d[9:6];
      c = d[13:10];
      lim = (model_count < POINTS) ? model_count : POINTS;
      case (kind)
         KIND_LOAD: begin
            if (a < POINTS) model_points[a] = {d[45:30], d[29:14]};
            else r.status = ST_RANGE;
         end
         KIND_DIST: begin
            if (a >= lim || b >= lim) begin
               r.status = ST_RANGE;
            end else begin
               dx = pt_x(b) - pt_x(a);
               dy = pt_y(b) - pt_y(a);
               n = (dx * dx + dy * dy) << 16;
               root = int_root(n);
               if (n - root * root > root) root++;
               r.distance = root[24:0];
            end
         end
         KIND_ANGLE: begin
            if (a >= lim || b >= lim || c >= lim) begin
               r.status = ST_RANGE;
            end else begin
               ax = pt_x(b) - pt_x(a); ay = pt_y(b) - pt_y(a);
               bx = pt_x(c) - pt_x(a); by = pt_y(c) - pt_y(a);
               if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
                  r.status = ST_ZERO;
               end else begin
                  dotp = ax * bx + ay * by;
                  crs = ax * by - ay * bx;
                  if (crs < 0) crs = -crs;
                  r.angle_degrees = cordic_angle(dotp, crs);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   assign pending_count = answers_due.size();

   // track config, predict on req transfer, compare on rsp transfer
   always @(posedge clock) begin
      answer_t got, want;
      if (reset) begin
         model_count <= '0;
         fail_count  <= 0;
         for (int k = 0; k < POINTS; k++) model_points[k] = '0;
      end else begin
         if (csr_wr_en) model_count <= csr_wr_data;
         if (req_tvalid && req_tready) answers_due.push_back(predict_answer(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = answer_t'(rsp_tdata[42:0]);
            if (answers_due.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (got !== want || rsp_tdata[47:43] !== 5'd0) begin
                  if (fail_count < 10)
                     $display("mismatch: status %0d/%0d dist %0d/%0d angle %0d/%0d",
                        want.status, got.status, want.distance, got.distance,
                        want.angle_degrees, got.angle_degrees);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top for point_store_distance_angle: clock, reset, stimulus and
// verdict. Depends on psda_pkg, the block and psda_checker.
`timescale 1ns / 100ps
module testbench;
   import psda_pkg::*;

   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, rsp_tready = 0, csr_wr_en = 0;
   logic [47:0] req_tdata = '0;
   logic [3:0]  csr_wr_data = '0;
   logic        req_tready, rsp_tvalid;
   logic [47:0] rsp_tdata;
   int          fail_count, pending_count;
   int          send_idle = 0, recv_stall = 0;
   bit          hold_rsp = 0;
   int          idle_cycles = 0;
   bit [7:0]    written = '0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   point_store_distance_angle u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_wr_en, .csr_wr_data);

   psda_checker u_check (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_wr_en, .csr_wr_data,
      .fail_count, .pending_count);

   // receiver: random stall, or a long hold-off when asked
   always @(posedge clock)
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall);

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_rsp)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // valid stays high between back-to-back items; dropped while idle
   task automatic send_item(logic [1:0] kind, logic [3:0] a, logic [3:0] b,
                            logic [3:0] c, logic [15:0] x, logic [15:0] y);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {2'b00, y, x, c, b, a, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == KIND_LOAD && a < POINTS) written[a] = 1;
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_point_count(logic [3:0] v);
      drain_results();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   // query index: mostly written slots, sometimes a random value that is never an unwritten slot
   function automatic logic [3:0] pick_index();
      logic [3:0] i;
      if ($urandom_range(9) == 0) begin
         i = $urandom;
         if (i < POINTS && !written[i]) i = i + POINTS;
      end else begin
         do i = $urandom_range(POINTS - 1); while (!written[i]);
      end
      return i;
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return $urandom_range(7) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [1:0] kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(9) < 3 ? KIND_LOAD :
                ($urandom_range(20) == 0 ? KIND_UNUSED : $urandom_range(2, 1));
         if (kind == KIND_LOAD)
            send_item(kind, $urandom_range(20) == 0 ? $urandom_range(15, 8)
                      : $urandom_range(7), $urandom, $urandom,
                      pick_coord(), pick_coord());
         else
            send_item(kind, pick_index(), pick_index(), pick_index(),
                      $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: loads of extremes, then every kind and special case
      set_point_count(4'd8);
      send_item(KIND_LOAD, 0, 0, 0, 16'h8000, 16'h8000);
      send_item(KIND_LOAD, 1, 0, 0, 16'h7fff, 16'h7fff);
      send_item(KIND_LOAD, 2, 0, 0, 16'h0000, 16'h0000);
      send_item(KIND_LOAD, 3, 0, 0, 16'h0005, 16'h0000);
      send_item(KIND_LOAD, 4, 0, 0, 16'hfffb, 16'h0000);
      send_item(KIND_LOAD, 5, 0, 0, 16'h0000, 16'h0005);
      send_item(KIND_LOAD, 6, 0, 0, 16'h0003, 16'h0004);
      send_item(KIND_LOAD, 7, 0, 0, 16'h8000, 16'h7fff);
      send_item(KIND_LOAD, 15, 0, 0, 16'h1234, 16'h5678);
      send_item(KIND_DIST, 0, 1, 0, 0, 0);
      send_item(KIND_DIST, 2, 6, 0, 0, 0);
      send_item(KIND_DIST, 3, 3, 0, 0, 0);
      send_item(KIND_DIST, 7, 8, 0, 0, 0);
      send_item(KIND_ANGLE, 2, 3, 4, 0, 0);
      send_item(KIND_ANGLE, 2, 3, 5, 0, 0);
      send_item(KIND_ANGLE, 2, 3, 3, 0, 0);
      send_item(KIND_ANGLE, 2, 2, 3, 0, 0);
      send_item(KIND_ANGLE, 0, 1, 7, 0, 0);
      send_item(KIND_ANGLE, 15, 1, 2, 0, 0);
      send_item(KIND_UNUSED, 15, 15, 15, 16'hffff, 16'hffff);
      set_point_count(4'd0);
      send_item(KIND_DIST, 0, 0, 0, 0, 0);
      set_point_count(4'd15);
      send_item(KIND_ANGLE, 1, 2, 6, 0, 0);

      // long receiver hold-off while the sender keeps offering
      hold_rsp = 1;
      fork
         begin repeat (400) @(posedge clock); hold_rsp = 0; end
         random_phase(6);
      join
      drain_results();

      // idling phases across several register settings
      random_phase(100);
      set_point_count(4'd3);
      send_idle = 62;
      random_phase(100);
      set_point_count(4'd8);
      send_idle = 0; recv_stall = 62;
      random_phase(100);
      set_point_count(4'd5);
      send_idle = 18; recv_stall = 18;
      random_phase(100);
      set_point_count(4'd8);
      send_idle = 0; recv_stall = 0;
      random_phase(100);

      drain_results();
      if (fail_count == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule
